### rtl/fun_pkg.sv
// ---------------------------------------------------------------------------
// fun_pkg: shared types and constants for the face unit normal block
// Beat layouts, field widths and command codes used by the unit, the normalizer and the bench.
// ---------------------------------------------------------------------------
package fun_pkg;

	localparam int VERTEX_COUNT = 1024;
	localparam int SLOT_W       = $clog2(VERTEX_COUNT);
	localparam int COORD_W      = 16;
	localparam int VERT_W       = 3 * COORD_W;
	localparam int EDGE_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * EDGE_W;
	localparam int CROSS_W      = PROD_W + 1;
	localparam int MAG_W        = PROD_W;
	localparam int UMAG_W       = 15;
	localparam int SQ_W         = 2 * UMAG_W;
	localparam int SUM_W        = SQ_W + 2;
	localparam int RS_W         = SUM_W + UMAG_W + 1;
	localparam int ACC_W        = 64;
	localparam int SH_W         = $clog2(MAG_W);
	localparam int BITS         = 15;
	localparam int RHS_SHIFT    = 30;
	localparam int OUT_W        = 16;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_FACE = 1'b1;

	typedef struct packed {
		logic                      cmd;
		logic [SLOT_W-1:0]         vertex_slot;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [SLOT_W-1:0]         first_index;
		logic [SLOT_W-1:0]         second_index;
		logic [SLOT_W-1:0]         third_index;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] normal_x;
		logic signed [OUT_W-1:0] normal_y;
		logic signed [OUT_W-1:0] normal_z;
		logic                    degenerate;
	} result_t;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  deg;
	} norm_in_t;

endpackage

### rtl/fun_ram.sv
// ---------------------------------------------------------------------------
// fun_ram: generic memory
// One write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module fun_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

### rtl/fun_norm.sv
// ---------------------------------------------------------------------------
// fun_norm: normalizing pipeline
// Range shift, squares, sum, then one result bit per stage for each
// component, sign and degenerate handling at the output register.
// ---------------------------------------------------------------------------
module fun_norm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  fun_pkg::norm_in_t din,
	output logic              done,
	output fun_pkg::result_t  result
);
	import fun_pkg::*;

	// stage 6: range shift
	logic [MAG_W-1:0]  mag_or;
	logic [SH_W-1:0]   msb;
	logic [SH_W-1:0]   sh;
	logic              vld_s6;
	logic [UMAG_W-1:0] m_s6 [3];
	logic [2:0]        neg_s6;
	logic              deg_s6;

	always_comb begin
		mag_or = din.mag[0] | din.mag[1] | din.mag[2];
		msb    = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (mag_or[i]) msb = SH_W'(i);
		end
		sh = (msb >= SH_W'(UMAG_W)) ? (msb - SH_W'(UMAG_W - 1)) : '0;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			m_s6[k] <= UMAG_W'(din.mag[k] >> sh);
		end
		neg_s6 <= din.neg;
		deg_s6 <= din.deg;
	end

	// stage 7: squares
	logic              vld_s7;
	logic [UMAG_W-1:0] m_s7 [3];
	logic [SQ_W-1:0]   sq_s7 [3];
	logic [2:0]        neg_s7;
	logic              deg_s7;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			m_s7[k]  <= m_s6[k];
			sq_s7[k] <= SQ_W'(m_s6[k]) * SQ_W'(m_s6[k]);
		end
		neg_s7 <= neg_s6;
		deg_s7 <= deg_s6;
	end

	// stage 8 (bit stage 0 input): sum of squares, clear the result state
	logic              vld_st [BITS+1];
	logic [SUM_W-1:0]  s_st   [BITS+1];
	logic [SQ_W-1:0]   m2_st  [BITS+1][3];
	logic [2:0]        neg_st [BITS+1];
	logic              deg_st [BITS+1];
	logic [UMAG_W-1:0] r_st   [BITS+1][3];
	logic [ACC_W-1:0]  r2s_st [BITS+1][3];
	logic [RS_W-1:0]   rs_st  [BITS+1][3];

	always_ff @(posedge clk) begin
		s_st[0] <= SUM_W'(sq_s7[0]) + SUM_W'(sq_s7[1]) + SUM_W'(sq_s7[2]);
		for (int k = 0; k < 3; k++) begin
			m2_st[0][k]  <= sq_s7[k];
			r_st[0][k]   <= '0;
			r2s_st[0][k] <= '0;
			rs_st[0][k]  <= '0;
		end
		neg_st[0] <= neg_s7;
		deg_st[0] <= deg_s7;
	end

	// bit stages: keep r*S and r*r*S so each trial needs adds only
	for (genvar j = 0; j < BITS; j++) begin : g_bit
		localparam int B = BITS - 1 - j;
		logic [ACC_W-1:0] cs  [3];
		logic [ACC_W-1:0] c2s [3];
		logic [ACC_W-1:0] tt  [3];
		logic [ACC_W-1:0] rhs [3];
		logic             tk  [3];

		always_comb begin
			for (int k = 0; k < 3; k++) begin
				cs[k]  = ACC_W'(rs_st[j][k]) + (ACC_W'(s_st[j]) << B);
				c2s[k] = r2s_st[j][k] + (ACC_W'(rs_st[j][k]) << (B + 1))
					+ (ACC_W'(s_st[j]) << (2 * B));
				tt[k]  = (c2s[k] << 2) - (cs[k] << 2) + ACC_W'(s_st[j]);
				rhs[k] = ACC_W'(m2_st[j][k]) << RHS_SHIFT;
				tk[k]  = !r_st[j][k][UMAG_W-1] && (tt[k] <= rhs[k]);
			end
		end

		always_ff @(posedge clk) begin
			for (int k = 0; k < 3; k++) begin
				m2_st[j+1][k] <= m2_st[j][k];
				if (tk[k]) begin
					r_st[j+1][k]   <= r_st[j][k] | UMAG_W'(1 << B);
					r2s_st[j+1][k] <= c2s[k];
					rs_st[j+1][k]  <= cs[k][RS_W-1:0];
				end else begin
					r_st[j+1][k]   <= r_st[j][k];
					r2s_st[j+1][k] <= r2s_st[j][k];
					rs_st[j+1][k]  <= rs_st[j][k];
				end
			end
			s_st[j+1]   <= s_st[j];
			neg_st[j+1] <= neg_st[j];
			deg_st[j+1] <= deg_st[j];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			for (int j = 0; j <= BITS; j++) vld_st[j] <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s6    <= vld;
			vld_s7    <= vld_s6;
			vld_st[0] <= vld_s7;
			for (int j = 0; j < BITS; j++) vld_st[j+1] <= vld_st[j];
			done      <= vld_st[BITS];
		end
	end

	// output register: sign and degenerate
	logic signed [OUT_W-1:0] comp [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			comp[k] = neg_st[BITS][k] ? -OUT_W'(r_st[BITS][k]) : OUT_W'(r_st[BITS][k]);
			if (deg_st[BITS]) comp[k] = '0;
		end
	end

	always_ff @(posedge clk) begin
		result.normal_x   <= comp[0];
		result.normal_y   <= comp[1];
		result.normal_z   <= comp[2];
		result.degenerate <= deg_st[BITS];
	end

endmodule

### rtl/face_unit_normal_unit.sv
// ---------------------------------------------------------------------------
// face_unit_normal_unit: triangle face unit normal over a vertex store
// Loads write vertices; a face reads three, forms the cross product of the
// edges from the first vertex and scales it to unit length in signed Q1.14.
// ---------------------------------------------------------------------------
//  channel  ports                 beat
//  input    start, busy, item     start & !busy, one load or face per beat
//  result   done, result          done high one cycle, one beat per face
//
//  a load leaves busy low; a face raises busy the cycle after it is taken,
//  as its three vertex reads share the two read ports of the store.
//  reset clears only valid bits; the store is undefined until written.
//  the receiver cannot stall; the pipeline never holds.
// ---------------------------------------------------------------------------
module face_unit_normal_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  fun_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output fun_pkg::result_t result
);
	import fun_pkg::*;

	logic              accept;
	logic              face_q;
	logic [SLOT_W-1:0] third_q;
	logic [SLOT_W-1:0] raddr0;
	logic [VERT_W-1:0] rdata0;
	logic [VERT_W-1:0] rdata1;

	assign accept = start && !busy;
	assign busy   = face_q;
	assign raddr0 = face_q ? third_q : item.first_index;

	// vertex store
	fun_ram #(.WIDTH(VERT_W), .DEPTH(VERTEX_COUNT)) u_store (
		.clk    (clk),
		.we     (accept && item.cmd == CMD_LOAD),
		.waddr  (item.vertex_slot),
		.wdata  ({item.coord_x, item.coord_y, item.coord_z}),
		.raddr0 (raddr0),
		.raddr1 (item.second_index),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	// second read cycle of a face
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_q <= 1'b0;
		end else begin
			face_q <= accept && item.cmd == CMD_FACE;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) third_q <= item.third_index;
	end

	// stage 1: vertices a and b
	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [VERT_W-1:0] a_s1, b_s1;

	always_ff @(posedge clk) begin
		a_s1 <= rdata0;
		b_s1 <= rdata1;
	end

	// stage 2: edges from the first vertex
	logic signed [EDGE_W-1:0] e1_s2 [3];
	logic signed [EDGE_W-1:0] e2_s2 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			e1_s2[k] <= EDGE_W'($signed(b_s1[VERT_W-1-k*COORD_W -: COORD_W]))
				- EDGE_W'($signed(a_s1[VERT_W-1-k*COORD_W -: COORD_W]));
			e2_s2[k] <= EDGE_W'($signed(rdata0[VERT_W-1-k*COORD_W -: COORD_W]))
				- EDGE_W'($signed(a_s1[VERT_W-1-k*COORD_W -: COORD_W]));
		end
	end

	// stage 3: cross product terms
	logic signed [PROD_W-1:0] p_s3 [6];

	always_ff @(posedge clk) begin
		p_s3[0] <= e1_s2[1] * e2_s2[2];
		p_s3[1] <= e1_s2[2] * e2_s2[1];
		p_s3[2] <= e1_s2[2] * e2_s2[0];
		p_s3[3] <= e1_s2[0] * e2_s2[2];
		p_s3[4] <= e1_s2[0] * e2_s2[1];
		p_s3[5] <= e1_s2[1] * e2_s2[0];
	end

	// stage 4: cross product
	logic signed [CROSS_W-1:0] n_s4 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			n_s4[k] <= CROSS_W'(p_s3[2*k]) - CROSS_W'(p_s3[2*k+1]);
		end
	end

	// stage 5: sign and magnitude
	norm_in_t nin_s5;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			nin_s5.neg[k] <= n_s4[k][CROSS_W-1];
			nin_s5.mag[k] <= n_s4[k][CROSS_W-1] ? MAG_W'(-n_s4[k]) : MAG_W'(n_s4[k]);
		end
		nin_s5.deg <= (n_s4[0] == '0) && (n_s4[1] == '0) && (n_s4[2] == '0);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= face_q;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	fun_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld_s5),
		.din    (nin_s5),
		.done   (done),
		.result (result)
	);

	// a face raises busy, a load does not, and busy is never high in back-to-back cycles
	a_busy_once: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("busy held two cycles");

	a_face_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.cmd == CMD_FACE) |=> busy) else $error("face without busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.cmd == CMD_LOAD) |=> !busy) else $error("load set busy");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.degenerate) |-> (result.normal_x == '0 && result.normal_y == '0
		&& result.normal_z == '0)) else $error("degenerate beat not zero");

endmodule

### test/tb_face_unit_normal_unit.sv
// ---------------------------------------------------------------------------
// tb_face_unit_normal_unit: self-checking bench for the face unit normal block
// Loads vertices and issues faces over written slots only, predicts each unit
// normal with an exact integer model and checks every result beat in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_face_unit_normal_unit;
	import fun_pkg::*;

	localparam int LATENCY   = 24;
	localparam int CYC_LIMIT = 400000;

	// scoreboard: vertex copy, normal predictor and queue of pending normals
	class normal_board;
		logic signed [15:0] vx [VERTEX_COUNT];
		logic signed [15:0] vy [VERTEX_COUNT];
		logic signed [15:0] vz [VERTEX_COUNT];
		result_t pending_normals [$];
		int errors;

		task report_mismatch(string what, result_t got, result_t want);
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		function logic [15:0] scale_mag(longint unsigned m, longint unsigned s);
			longint unsigned r, c, t;
			r = 0;
			for (int b = 14; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if (c <= 16384) begin
					t = 2 * c - 1;
					if (t * t * s <= ((m * m) << 30))
						r = c;
				end
			end
			return r[15:0];
		endfunction

		function result_t face_normal(item_t it);
			longint a[3], b[3], c[3], e1[3], e2[3], n[3];
			longint unsigned mag[3], mx, s;
			logic [15:0] r;
			result_t res;
			a = '{vx[it.first_index], vy[it.first_index], vz[it.first_index]};
			b = '{vx[it.second_index], vy[it.second_index], vz[it.second_index]};
			c = '{vx[it.third_index], vy[it.third_index], vz[it.third_index]};
			for (int k = 0; k < 3; k++) begin
				e1[k] = b[k] - a[k];
				e2[k] = c[k] - a[k];
			end
			n[0] = e1[1] * e2[2] - e1[2] * e2[1];
			n[1] = e1[2] * e2[0] - e1[0] * e2[2];
			n[2] = e1[0] * e2[1] - e1[1] * e2[0];
			res = '0;
			if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
				res.degenerate = 1'b1;
				return res;
			end
			mx = 0;
			for (int k = 0; k < 3; k++) begin
				mag[k] = (n[k] < 0) ? -n[k] : n[k];
				if (mag[k] > mx) mx = mag[k];
			end
			while (mx >= 32768) begin
				mx >>= 1;
				for (int k = 0; k < 3; k++) mag[k] >>= 1;
			end
			s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
			r = scale_mag(mag[0], s); res.normal_x = (n[0] < 0) ? -r : r;
			r = scale_mag(mag[1], s); res.normal_y = (n[1] < 0) ? -r : r;
			r = scale_mag(mag[2], s); res.normal_z = (n[2] < 0) ? -r : r;
			return res;
		endfunction

		function void note_item(item_t it);
			if (it.cmd == CMD_LOAD) begin
				vx[it.vertex_slot] = it.coord_x;
				vy[it.vertex_slot] = it.coord_y;
				vz[it.vertex_slot] = it.coord_z;
			end else
				pending_normals = {pending_normals, face_normal(it)};
		endfunction

		task check_result(result_t got);
			result_t want;
			if (pending_normals.size() == 0) begin
				report_mismatch("result beat with no face pending", got, got);
				return;
			end
			want = pending_normals.pop_front();
			if (got.normal_x !== want.normal_x) report_mismatch("normal_x", got, want);
			if (got.normal_y !== want.normal_y) report_mismatch("normal_y", got, want);
			if (got.normal_z !== want.normal_z) report_mismatch("normal_z", got, want);
			if (got.degenerate !== want.degenerate) report_mismatch("degenerate", got, want);
		endtask
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy, done;
	result_t result;

	normal_board board = new();
	bit written [VERTEX_COUNT];
	int written_slots [$];
	int send_idle_pct = 0;
	int cycles = 0;

	face_unit_normal_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .done(done), .result(result)
	);

	always #2 clk = ~clk;

	// result side: the block cannot be stalled, so just check every beat
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(result);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// drive one beat, holding start until it is taken
	task automatic send_beat(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_item(it);
	endtask

	task automatic load_vertex(int slot, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		item_t it;
		it = item_t'($bits(item_t)'({$urandom, $urandom, $urandom}));
		it.cmd = CMD_LOAD;
		it.vertex_slot = SLOT_W'(slot);
		it.coord_x = x; it.coord_y = y; it.coord_z = z;
		if (!written[slot]) begin
			written[slot] = 1'b1;
			written_slots = {written_slots, slot};
		end
		send_beat(it);
	endtask

	task automatic issue_face(int a, int b, int c);
		item_t it;
		it = item_t'($bits(item_t)'({$urandom, $urandom, $urandom}));
		it.cmd = CMD_FACE;
		it.first_index = SLOT_W'(a); it.second_index = SLOT_W'(b);
		it.third_index = SLOT_W'(c);
		send_beat(it);
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
			1: return 16'($urandom_range(15) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_written();
		return written_slots[$urandom_range(written_slots.size() - 1)];
	endfunction

	task automatic random_beats(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 40)
				load_vertex($urandom_range(VERTEX_COUNT - 1), rand_coord(), rand_coord(),
					rand_coord());
			else if ($urandom_range(9) == 0)
				issue_face(pick_written(), pick_written(), pick_written());
			else begin
				int a;
				a = pick_written();
				issue_face(a, pick_written(), $urandom_range(4) == 0 ? a : pick_written());
			end
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (board.pending_normals.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, end slots, degenerate faces
		load_vertex(0, 16'h0000, 16'h0000, 16'h0000);
		load_vertex(1, 16'h0100, 16'h0000, 16'h0000);
		load_vertex(2, 16'h0000, 16'h0100, 16'h0000);
		load_vertex(1023, 16'h7fff, 16'h7fff, 16'h7fff);
		load_vertex(1022, 16'h8000, 16'h8000, 16'h8000);
		load_vertex(3, 16'h8000, 16'h7fff, 16'h8000);
		load_vertex(4, 16'h7fff, 16'h8000, 16'h0001);
		load_vertex(5, 16'hffff, 16'h0001, 16'hffff);
		issue_face(0, 1, 2);
		issue_face(0, 2, 1);
		issue_face(0, 0, 0);
		issue_face(0, 1023, 1022);
		issue_face(1022, 3, 4);
		issue_face(3, 4, 1023);
		issue_face(1023, 1022, 0);
		issue_face(5, 1, 5);
		issue_face(0, 1, 2);
		issue_face(4, 1022, 1023);
		issue_face(5, 3, 2);
		wait_drained();

		send_idle_pct = 29;
		random_beats(600);
		// pause until every pending normal has come
		wait_drained();
		send_idle_pct = 71;
		random_beats(550);
		send_idle_pct = 0;
		random_beats(600);
		wait_drained();

		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
